[rtl/core/lmra_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmra_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package lmra_pkg;

  localparam int NUM_BLOCKS     = 1024;
  localparam int LINES_IN_BLOCK = 256;
  localparam int BYTES_PER_LINE = 128;
  localparam int BLK_BYTES      = LINES_IN_BLOCK * BYTES_PER_LINE;

  localparam int BLK_W   = $clog2(NUM_BLOCKS);
  localparam int LINE_W  = $clog2(LINES_IN_BLOCK);
  localparam int LCNT_W  = LINE_W + 1;
  localparam int BYTE_W  = $clog2(BYTES_PER_LINE);
  localparam int OFF_W   = 25;
  localparam int LIVE_W  = 26;
  localparam int SIZE_W  = 15;
  localparam int TOT_W   = 16;
  localparam int CHUNK_W = LINE_W - 3;
  localparam int ACC_W   = BLK_W + LINE_W + 1;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_MARK  = 2'd1,
    OP_SWEEP = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_FREE  = 2'd0,
    KIND_RECYC = 2'd1,
    KIND_USED  = 2'd2
  } kind_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_INIT,
    DP_LOAD,
    DP_BUMP,
    DP_REFUSE,
    DP_SEARCH_START,
    DP_RD_BLK,
    DP_LOAD_ROW,
    DP_SCAN,
    DP_HIT,
    DP_SKIP_BLK,
    DP_FRESH,
    DP_FAIL,
    DP_MARK_RD,
    DP_MARK_WR,
    DP_WALK_START,
    DP_SWEEP_CNT,
    DP_NEXT_BLK,
    DP_SWEEP_END,
    DP_CLEAR_WR,
    DP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic init_last;
    op_t  op;
    logic oversize;
    logic bump_fit;
    logic kind_used;
    logic scan_hit;
    logic scan_end;
    logic blk_last;
    logic arena_full;
    logic chunk_last;
  } dp_stat_t;

endpackage

[rtl/core/lmra_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmra_dp
// line mark and block kind memories, cursors, bump hole and walk counters
// ----------------------------------------------------------------------------
module lmra_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lmra_pkg::dp_cmd_t        cmd,
  output lmra_pkg::dp_stat_t       stat,
  input  logic [1:0]               in_opcode,
  input  logic [14:0]              in_size_bytes,
  input  logic [24:0]              in_object_offset,
  output logic                     out_granted,
  output logic [24:0]              out_alloc_offset,
  output logic [25:0]              out_live_bytes
);
  import lmra_pkg::*;

  // memories
  logic [LINES_IN_BLOCK-1:0] line_mem [NUM_BLOCKS];
  kind_t                     kind_mem [NUM_BLOCKS];
  logic [LINES_IN_BLOCK-1:0] line_rd_r;
  kind_t                     kind_rd_r;

  logic                      line_we, line_re;
  logic [BLK_W-1:0]          line_waddr, rd_addr;
  logic [LINES_IN_BLOCK-1:0] line_wdata;
  logic                      kind_we;
  logic [BLK_W-1:0]          kind_waddr;
  kind_t                     kind_wdata;

  // registers
  op_t               op_r, op_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic [LCNT_W-1:0] need_r, need_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [BLK_W-1:0]  search_block_r, search_block_nxt;
  logic [LCNT_W-1:0] search_line_r, search_line_nxt;
  logic [BLK_W-1:0]  touched_high_r, touched_high_nxt;
  logic [LIVE_W-1:0] bump_next_r, bump_next_nxt;
  logic [LIVE_W-1:0] bump_limit_r, bump_limit_nxt;
  logic              bump_valid_r, bump_valid_nxt;
  logic [BLK_W-1:0]  blk_r, blk_nxt;
  logic [LCNT_W-1:0] i_r, i_nxt;
  logic [LCNT_W-1:0] start_r, start_nxt;
  logic              inrun_r, inrun_nxt;
  logic [CHUNK_W-1:0] chunk_r, chunk_nxt;
  logic [LCNT_W-1:0] marked_r, marked_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [BLK_W-1:0]  init_cnt_r, init_cnt_nxt;
  logic              pend_granted_r, pend_granted_nxt;
  logic [OFF_W-1:0]  pend_off_r, pend_off_nxt;
  logic [LIVE_W-1:0] pend_live_r, pend_live_nxt;
  logic              res_granted_r, res_granted_nxt;
  logic [OFF_W-1:0]  res_off_r, res_off_nxt;
  logic [LIVE_W-1:0] res_live_r, res_live_nxt;

  // size rounding
  logic [SIZE_W-1:0] size_min;
  logic [TOT_W-1:0]  total_in;
  logic [TOT_W-1:0]  need_sum;

  assign size_min = (in_size_bytes < SIZE_W'(8)) ? SIZE_W'(8) : in_size_bytes;
  assign total_in = (TOT_W'(size_min) + TOT_W'(7)) & ~TOT_W'(7);
  assign need_sum = total_in + TOT_W'(BYTES_PER_LINE - 1);

  // scan of the loaded row, one line per step
  logic              cur_bit, at_end, run_ok;
  logic [LCNT_W-1:0] run_len;
  logic [OFF_W-1:0]  run_base;
  logic [LIVE_W-1:0] hole_end;

  assign cur_bit    = line_rd_r[i_r[LINE_W-1:0]];
  assign at_end     = i_r[LINE_W];
  assign run_len    = i_r - start_r;
  assign run_ok     = inrun_r && (run_len >= need_r);
  assign run_base   = {blk_r, start_r[LINE_W-1:0], BYTE_W'(0)};
  assign hole_end   = {1'b0, blk_r, (LINE_W + BYTE_W)'(0)} +
                      LIVE_W'({i_r, BYTE_W'(0)});

  // fresh block
  logic [BLK_W-1:0]  fresh_blk;
  logic [OFF_W-1:0]  fresh_start;
  assign fresh_blk   = touched_high_r + BLK_W'(1);
  assign fresh_start = {fresh_blk, (LINE_W + BYTE_W)'(0)};

  // mark range
  logic [BLK_W-1:0]          mark_blk;
  logic [LINE_W-1:0]         mark_l0, mark_l1;
  logic [LIVE_W-1:0]         mark_last;
  logic [LINES_IN_BLOCK-1:0] mark_mask;

  assign mark_blk  = off_r[OFF_W-1 -: BLK_W];
  assign mark_l0   = off_r[BYTE_W +: LINE_W];
  assign mark_last = {1'b0, off_r} + LIVE_W'(total_r) - LIVE_W'(1);
  assign mark_l1   = (mark_last[LIVE_W-1:LINE_W+BYTE_W] != {1'b0, mark_blk}) ?
                     {LINE_W{1'b1}} : mark_last[BYTE_W +: LINE_W];

  always_comb begin
    for (int j = 0; j < LINES_IN_BLOCK; j++) begin
      mark_mask[j] = (LINE_W'(j) >= mark_l0) && (LINE_W'(j) <= mark_l1);
    end
  end

  // sweep count, eight lines a step
  logic [7:0]        chunk_bits;
  logic [3:0]        chunk_pc;
  logic [LCNT_W-1:0] marked_fin;
  kind_t             sweep_kind;

  assign chunk_bits = line_rd_r[{chunk_r, 3'b000} +: 8];

  always_comb begin
    chunk_pc = 4'd0;
    for (int k = 0; k < 8; k++) begin
      chunk_pc = chunk_pc + 4'(chunk_bits[k]);
    end
  end

  assign marked_fin = marked_r + LCNT_W'(chunk_pc);

  always_comb begin
    if (marked_fin == '0) begin
      sweep_kind = KIND_FREE;
    end else if (marked_fin == LCNT_W'(LINES_IN_BLOCK)) begin
      sweep_kind = KIND_USED;
    end else begin
      sweep_kind = KIND_RECYC;
    end
  end

  // memory ports
  always_comb begin
    line_we    = 1'b0;
    line_re    = 1'b0;
    line_waddr = blk_r;
    line_wdata = '0;
    rd_addr    = blk_r;
    kind_we    = 1'b0;
    kind_waddr = blk_r;
    kind_wdata = KIND_FREE;
    case (cmd.op)
      DP_INIT: begin
        line_we    = 1'b1;
        line_waddr = init_cnt_r;
        kind_we    = 1'b1;
        kind_waddr = init_cnt_r;
      end
      DP_RD_BLK: begin
        line_re = 1'b1;
      end
      DP_MARK_RD: begin
        line_re = 1'b1;
        rd_addr = mark_blk;
      end
      DP_MARK_WR: begin
        line_we    = 1'b1;
        line_waddr = mark_blk;
        line_wdata = line_rd_r | mark_mask;
      end
      DP_CLEAR_WR: begin
        line_we = 1'b1;
      end
      DP_SWEEP_CNT: begin
        kind_we    = &chunk_r;
        kind_wdata = sweep_kind;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[line_waddr] <= line_wdata;
    end
    if (line_re) begin
      line_rd_r <= line_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (kind_we) begin
      kind_mem[kind_waddr] <= kind_wdata;
    end
    if (line_re) begin
      kind_rd_r <= kind_mem[rd_addr];
    end
  end

  // next state
  always_comb begin
    op_nxt           = op_r;
    total_nxt        = total_r;
    need_nxt         = need_r;
    off_nxt          = off_r;
    search_block_nxt = search_block_r;
    search_line_nxt  = search_line_r;
    touched_high_nxt = touched_high_r;
    bump_next_nxt    = bump_next_r;
    bump_limit_nxt   = bump_limit_r;
    bump_valid_nxt   = bump_valid_r;
    blk_nxt          = blk_r;
    i_nxt            = i_r;
    start_nxt        = start_r;
    inrun_nxt        = inrun_r;
    chunk_nxt        = chunk_r;
    marked_nxt       = marked_r;
    acc_nxt          = acc_r;
    init_cnt_nxt     = init_cnt_r;
    pend_granted_nxt = pend_granted_r;
    pend_off_nxt     = pend_off_r;
    pend_live_nxt    = pend_live_r;
    res_granted_nxt  = res_granted_r;
    res_off_nxt      = res_off_r;
    res_live_nxt     = res_live_r;
    case (cmd.op)
      DP_INIT: begin
        init_cnt_nxt = init_cnt_r + BLK_W'(1);
      end
      DP_LOAD: begin
        op_nxt           = op_t'(in_opcode);
        total_nxt        = total_in;
        need_nxt         = need_sum[BYTE_W +: LCNT_W];
        off_nxt          = in_object_offset;
        pend_granted_nxt = 1'b1;
        pend_off_nxt     = '0;
        pend_live_nxt    = '0;
      end
      DP_BUMP: begin
        pend_off_nxt  = bump_next_r[OFF_W-1:0];
        bump_next_nxt = bump_next_r + LIVE_W'(total_r);
      end
      DP_REFUSE, DP_FAIL: begin
        pend_granted_nxt = 1'b0;
        pend_off_nxt     = '0;
      end
      DP_SEARCH_START: begin
        blk_nxt = search_block_r;
      end
      DP_RD_BLK: begin
        chunk_nxt  = '0;
        marked_nxt = '0;
      end
      DP_LOAD_ROW: begin
        i_nxt     = search_line_r;
        start_nxt = '0;
        inrun_nxt = 1'b0;
      end
      DP_SCAN: begin
        if (!at_end) begin
          if (!inrun_r) begin
            if (!cur_bit) begin
              start_nxt = i_r;
              inrun_nxt = 1'b1;
            end
            i_nxt = i_r + LCNT_W'(1);
          end else if (!cur_bit) begin
            i_nxt = i_r + LCNT_W'(1);
          end else begin
            inrun_nxt = 1'b0;
          end
        end
      end
      DP_HIT: begin
        search_block_nxt = blk_r;
        search_line_nxt  = i_r;
        bump_next_nxt    = {1'b0, run_base} + LIVE_W'(total_r);
        bump_limit_nxt   = hole_end;
        bump_valid_nxt   = 1'b1;
        pend_off_nxt     = run_base;
      end
      DP_SKIP_BLK: begin
        search_line_nxt = '0;
        blk_nxt         = blk_r + BLK_W'(1);
      end
      DP_FRESH: begin
        touched_high_nxt = fresh_blk;
        search_block_nxt = fresh_blk;
        search_line_nxt  = LCNT_W'(LINES_IN_BLOCK);
        bump_next_nxt    = {1'b0, fresh_start} + LIVE_W'(total_r);
        bump_limit_nxt   = {1'b0, fresh_start} + LIVE_W'(BLK_BYTES);
        bump_valid_nxt   = 1'b1;
        pend_off_nxt     = fresh_start;
      end
      DP_WALK_START: begin
        blk_nxt = '0;
        acc_nxt = '0;
      end
      DP_SWEEP_CNT: begin
        chunk_nxt  = chunk_r + CHUNK_W'(1);
        marked_nxt = marked_fin;
        if (&chunk_r) begin
          acc_nxt = acc_r + ACC_W'(marked_fin);
        end
      end
      DP_NEXT_BLK, DP_CLEAR_WR: begin
        blk_nxt = blk_r + BLK_W'(1);
      end
      DP_SWEEP_END: begin
        pend_live_nxt    = LIVE_W'({acc_r, BYTE_W'(0)});
        search_block_nxt = '0;
        search_line_nxt  = '0;
        bump_next_nxt    = '0;
        bump_limit_nxt   = '0;
        bump_valid_nxt   = 1'b0;
      end
      DP_PUBLISH: begin
        res_granted_nxt = pend_granted_r;
        res_off_nxt     = pend_off_r;
        res_live_nxt    = pend_live_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_block_r <= '0;
      search_line_r  <= '0;
      touched_high_r <= '0;
      bump_next_r    <= '0;
      bump_limit_r   <= '0;
      bump_valid_r   <= 1'b0;
      init_cnt_r     <= '0;
    end else begin
      search_block_r <= search_block_nxt;
      search_line_r  <= search_line_nxt;
      touched_high_r <= touched_high_nxt;
      bump_next_r    <= bump_next_nxt;
      bump_limit_r   <= bump_limit_nxt;
      bump_valid_r   <= bump_valid_nxt;
      init_cnt_r     <= init_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r           <= op_nxt;
    total_r        <= total_nxt;
    need_r         <= need_nxt;
    off_r          <= off_nxt;
    blk_r          <= blk_nxt;
    i_r            <= i_nxt;
    start_r        <= start_nxt;
    inrun_r        <= inrun_nxt;
    chunk_r        <= chunk_nxt;
    marked_r       <= marked_nxt;
    acc_r          <= acc_nxt;
    pend_granted_r <= pend_granted_nxt;
    pend_off_r     <= pend_off_nxt;
    pend_live_r    <= pend_live_nxt;
    res_granted_r  <= res_granted_nxt;
    res_off_r      <= res_off_nxt;
    res_live_r     <= res_live_nxt;
  end

  // status
  assign stat.init_last  = &init_cnt_r;
  assign stat.op         = op_r;
  assign stat.oversize   = total_r > TOT_W'(BLK_BYTES);
  assign stat.bump_fit   = bump_valid_r &&
                           (({1'b0, bump_next_r} + (LIVE_W + 1)'(total_r)) <=
                            {1'b0, bump_limit_r});
  assign stat.kind_used  = kind_rd_r == KIND_USED;
  assign stat.scan_hit   = (at_end || cur_bit) && run_ok;
  assign stat.scan_end   = at_end && !run_ok;
  assign stat.blk_last   = blk_r == touched_high_r;
  assign stat.arena_full = &touched_high_r;
  assign stat.chunk_last = &chunk_r;

  assign out_granted      = res_granted_r;
  assign out_alloc_offset = res_off_r;
  assign out_live_bytes   = res_live_r;

`ifndef SYNTHESIS
  a_hole_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == DP_HIT |=> bump_valid_r && (bump_next_r <= bump_limit_r))
    else $error("hole end below bump pointer");

  a_touched_grows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> touched_high_r >= $past(touched_high_r))
    else $error("touched high mark went down");

  a_cursor_touched: assert property (@(posedge clk) disable iff (!rst_n)
    search_block_r <= touched_high_r)
    else $error("search cursor beyond touched blocks");
`endif

endmodule

[rtl/core/lmra_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmra_ctrl
// sequencer for alloc, mark, sweep and clear, plus the reset clearing pass
// ----------------------------------------------------------------------------
module lmra_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output lmra_pkg::dp_cmd_t  cmd,
  input  lmra_pkg::dp_stat_t stat
);
  import lmra_pkg::*;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DISPATCH,
    S_A_RD,
    S_A_CHK,
    S_A_SCAN,
    S_A_FRESH,
    S_M_WR,
    S_S_RD,
    S_S_CNT,
    S_S_NEXT,
    S_C_WR,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = DP_NOP;
    case (state_r)
      S_INIT: begin
        cmd.op = DP_INIT;
        if (stat.init_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = DP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.op)
          OP_ALLOC: begin
            if (stat.oversize) begin
              cmd.op    = DP_REFUSE;
              state_nxt = S_FIN;
            end else if (stat.bump_fit) begin
              cmd.op    = DP_BUMP;
              state_nxt = S_FIN;
            end else begin
              cmd.op    = DP_SEARCH_START;
              state_nxt = S_A_RD;
            end
          end
          OP_MARK: begin
            cmd.op    = DP_MARK_RD;
            state_nxt = S_M_WR;
          end
          OP_SWEEP: begin
            cmd.op    = DP_WALK_START;
            state_nxt = S_S_RD;
          end
          default: begin
            cmd.op    = DP_WALK_START;
            state_nxt = S_C_WR;
          end
        endcase
      end
      S_A_RD: begin
        cmd.op    = DP_RD_BLK;
        state_nxt = S_A_CHK;
      end
      S_A_CHK: begin
        if (stat.kind_used) begin
          cmd.op    = DP_SKIP_BLK;
          state_nxt = stat.blk_last ? S_A_FRESH : S_A_RD;
        end else begin
          cmd.op    = DP_LOAD_ROW;
          state_nxt = S_A_SCAN;
        end
      end
      S_A_SCAN: begin
        if (stat.scan_hit) begin
          cmd.op    = DP_HIT;
          state_nxt = S_FIN;
        end else if (stat.scan_end) begin
          cmd.op    = DP_SKIP_BLK;
          state_nxt = stat.blk_last ? S_A_FRESH : S_A_RD;
        end else begin
          cmd.op = DP_SCAN;
        end
      end
      S_A_FRESH: begin
        cmd.op    = stat.arena_full ? DP_FAIL : DP_FRESH;
        state_nxt = S_FIN;
      end
      S_M_WR: begin
        cmd.op    = DP_MARK_WR;
        state_nxt = S_FIN;
      end
      S_S_RD: begin
        cmd.op    = DP_RD_BLK;
        state_nxt = S_S_CNT;
      end
      S_S_CNT: begin
        cmd.op = DP_SWEEP_CNT;
        if (stat.chunk_last) begin
          state_nxt = S_S_NEXT;
        end
      end
      S_S_NEXT: begin
        if (stat.blk_last) begin
          cmd.op    = DP_SWEEP_END;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = DP_NEXT_BLK;
          state_nxt = S_S_RD;
        end
      end
      S_C_WR: begin
        cmd.op = DP_CLEAR_WR;
        if (stat.blk_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.op        = DP_PUBLISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> state_r == S_INIT && !out_valid_r)
    else $error("reset did not start clearing pass");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_DISPATCH)
    else $error("accepted item not dispatched");

  a_publish: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && out_free |=> out_valid_r && state_r == S_IDLE)
    else $error("finished item not presented");
`endif

endmodule

[rtl/core/line_mark_region_allocator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_mark_region_allocator_core
// block and line mark-region allocator: alloc, mark, sweep and clear
// ----------------------------------------------------------------------------
// one item at a time. after reset a clearing pass zeroes the line marks and
// block kinds before the first item is taken. a bump alloc is accepted,
// dispatched and published. a hole search reads each visited block and
// checks its kind, then scans line by line (one more step at the end of each
// free run) in blocks that are not full; when the touched blocks run out, a
// fresh block is taken. mark is a read-modify-write of one block row. sweep
// reads each touched block and counts its marks eight lines a cycle. clear
// writes one block row per cycle over the touched blocks. the line mark
// memory with its single read and write port sets the pace of all of these.
// a finished item sits in the output register while the block goes back to
// idle.
// ----------------------------------------------------------------------------
module line_mark_region_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [14:0] in_size_bytes,
  input  logic [24:0] in_object_offset,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_granted,
  output logic [24:0] out_alloc_offset,
  output logic [25:0] out_live_bytes
);
  import lmra_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: owns the handshake and the item flow
  lmra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // datapath: memories, cursors, hole and result registers
  lmra_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_opcode        (in_opcode),
    .in_size_bytes    (in_size_bytes),
    .in_object_offset (in_object_offset),
    .out_granted      (out_granted),
    .out_alloc_offset (out_alloc_offset),
    .out_live_bytes   (out_live_bytes)
  );

endmodule
